// ===== src/brb_pkg.sv =====
// Shared types and constants for the byte ring buffer.
package brb_pkg;

    localparam int DATA_W    = 8;   // byte width
    localparam int CNT_W     = 12;  // offset, count, moved and fill field width
    localparam int CAP_W     = 4;   // capacity_log2 register width
    localparam int CAP_RESET = 12;  // capacity_log2 after reset
    localparam int CAP_MIN   = 1;   // smallest usable capacity_log2

    localparam int S_TDATA_W = DATA_W + CNT_W + CNT_W;          // 32
    localparam int M_FIELD_W = DATA_W + 1 + CNT_W + CNT_W;      // 33
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;       // 40

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_POP   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_SKIP  = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic  load;    // input transfer this cycle, capture result
        t_mode op;      // operation of the transfer
        logic  mem_wr;  // store byte at tail
        logic  mem_rd;  // read byte for pop or peek
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_space;  // write would succeed
        logic has_data;   // pop would succeed
        logic peek_ok;    // offset below fill level
    } t_stat;

endpackage

// ===== src/byte_ring_buffer.sv =====
// Top level of the circular byte FIFO: stream ports, controller and datapath.
//
//   channel  | direction | handshake            | content
//   ---------+-----------+----------------------+------------------------------------
//   s (op)   | in        | i_s_tvalid/o_s_tready| tuser mode, tdata data_in/offset/count
//   m (res)  | out       | o_m_tvalid/i_m_tready| tdata data_out/done/moved/fill_level
//   cfg      | in        | i_cfg_we             | capacity_log2, no read-back
//
// Each operation's result is registered at the transfer edge and shown in the next
// cycle. The single-port byte memory (one write or one read per cycle) and the one
// result register allow one result in flight at a time.
// A new transfer is taken while the result register is empty or in the cycle its
// result leaves, so with i_m_tready high one operation completes every cycle.
// A result stalled by i_m_tready low holds the input side off.
// Synchronous active-low reset clears indices, controller state and capacity_log2
// (to 12); the memory is not cleared.
module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int DEPTH_LOG2 = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // operation stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [7:0] data_in, [19:8] offset, [31:20] count
    input  logic [1:0]           i_s_tuser,   // [1:0] mode
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [7:0] data_out, [8] done_res,
                                              // [20:9] moved_count, [32:21] fill_level
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata  // capacity_log2
);

    t_cmd              cmd;
    t_stat             stat;
    t_mode             op;
    logic [DATA_W-1:0] data_out;
    logic              done_res;
    logic [CNT_W-1:0]  moved_count;
    logic [CNT_W-1:0]  fill_level;

    assign op = t_mode'(i_s_tuser);

    brb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (op),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    brb_dp #(
        .DEPTH_LOG2 (DEPTH_LOG2)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (cmd),
        .i_data_in     (i_s_tdata[DATA_W-1:0]),
        .i_offset      (i_s_tdata[DATA_W+CNT_W-1:DATA_W]),
        .i_count       (i_s_tdata[DATA_W+2*CNT_W-1:DATA_W+CNT_W]),
        .o_stat        (stat),
        .o_data_out    (data_out),
        .o_done_res    (done_res),
        .o_moved_count (moved_count),
        .o_fill_level  (fill_level)
    );

    // pack result fields from bit 0 up, pad to whole bytes
    assign o_m_tdata = M_TDATA_W'({fill_level, moved_count, done_res, data_out});

endmodule

// ===== src/brb_ctrl.sv =====
// Handshake controller: accepts operations, issues datapath commands, holds result valid.
module brb_ctrl
    import brb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_s_tvalid,
    output logic   o_s_tready,
    input  t_mode  i_op,
    output logic   o_m_tvalid,
    input  logic   i_m_tready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (load) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_m_tready) n_state = load ? ST_HOLD : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_HOLD: begin
                o_m_tvalid = 1'b1;
                o_s_tready = i_m_tready;  // slot frees as the result leaves
            end
            default: ;
        endcase
        load         = i_s_tvalid && o_s_tready;
        o_cmd.load   = load;
        o_cmd.op     = i_op;
        o_cmd.mem_wr = load && (i_op == MODE_WRITE) && i_stat.has_space;
        o_cmd.mem_rd = load && (((i_op == MODE_POP) && i_stat.has_data) ||
                                ((i_op == MODE_PEEK) && i_stat.peek_ok));
    end

`ifndef SYNTHESIS
    a_wr_only_with_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_wr |-> (load && (i_op == MODE_WRITE) && i_stat.has_space))
        else $error("byte stored without a write transfer or without space");

    a_rd_only_pop_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_rd |-> (load && ((i_op == MODE_POP) || (i_op == MODE_PEEK))))
        else $error("memory read outside pop or peek");

    a_no_wr_and_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mem_wr && o_cmd.mem_rd))
        else $error("memory write and read in one cycle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_m_tvalid)
        else $error("accepted operation gave no result");
`endif

endmodule

// ===== src/brb_dp.sv =====
// Datapath: indices, capacity mask, byte memory and result registers.
module brb_dp
    import brb_pkg::*;
#(
    parameter int DEPTH_LOG2 = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    input  t_cmd                 i_cmd,
    input  logic [DATA_W-1:0]    i_data_in,
    input  logic [CNT_W-1:0]     i_offset,
    input  logic [CNT_W-1:0]     i_count,
    output t_stat                o_stat,
    output logic [DATA_W-1:0]    o_data_out,
    output logic                 o_done_res,
    output logic [CNT_W-1:0]     o_moved_count,
    output logic [CNT_W-1:0]     o_fill_level
);

    localparam int DL = DEPTH_LOG2;
    localparam int W  = (DL > CNT_W) ? DL : CNT_W;  // compare width

    // size mask for a capacity_log2 value, clamped to 1..DL
    function automatic logic [DL-1:0] f_mask(input logic [CAP_W-1:0] cap);
        int            k;
        logic [DL-1:0] m;
        k = int'(cap);
        if (k < CAP_MIN) k = CAP_MIN;
        if (k > DL) k = DL;
        for (int i = 0; i < DL; i++) m[i] = (i < k);
        return m;
    endfunction

    logic [DL-1:0]     r_mask;
    logic [DL-1:0]     r_head;
    logic [DL-1:0]     r_tail;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_sel;
    logic              r_done;
    logic [CNT_W-1:0]  r_moved;
    logic [CNT_W-1:0]  r_fill;

    logic [DATA_W-1:0] mem [2**DL];

    logic [DL-1:0]    head, tail, fill, rd_addr;
    logic [W-1:0]     fill_w, moved_w, peek_w, skip_w, fill_out_w;
    logic [DL-1:0]    n_head, n_tail, n_fill;
    logic             n_done;
    logic [CNT_W-1:0] n_moved;

    always_comb begin
        head    = r_head & r_mask;
        tail    = r_tail & r_mask;
        fill    = (tail - head) & r_mask;
        fill_w  = W'(fill);
        moved_w = (W'(i_count) < fill_w) ? W'(i_count) : fill_w;
        peek_w  = W'(head) + W'(i_offset);
        skip_w  = W'(head) + moved_w;

        o_stat.has_space = (fill != r_mask);
        o_stat.has_data  = (fill != '0);
        o_stat.peek_ok   = (W'(i_offset) < fill_w);

        rd_addr = (i_cmd.op == MODE_POP) ? head : (peek_w[DL-1:0] & r_mask);

        n_head  = head;
        n_tail  = tail;
        n_fill  = fill;
        n_done  = 1'b0;
        n_moved = '0;
        unique case (i_cmd.op)
            MODE_WRITE: begin
                if (i_cmd.mem_wr) begin
                    n_tail = (tail + 1'b1) & r_mask;
                    n_fill = fill + 1'b1;
                    n_done = 1'b1;
                end
                n_moved = CNT_W'(n_done);
            end
            MODE_POP: begin
                if (i_cmd.mem_rd) begin
                    n_head = (head + 1'b1) & r_mask;
                    n_fill = fill - 1'b1;
                    n_done = 1'b1;
                end
                n_moved = CNT_W'(n_done);
            end
            MODE_PEEK: begin
                n_done  = i_cmd.mem_rd;
                n_moved = CNT_W'(n_done);
            end
            MODE_SKIP: begin
                n_moved = moved_w[CNT_W-1:0];
                n_head  = skip_w[DL-1:0] & r_mask;
                n_fill  = fill - moved_w[DL-1:0];
                n_done  = (moved_w != '0);
            end
            default: ;
        endcase
        fill_out_w = W'(n_fill);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= f_mask(CAP_W'(CAP_RESET));
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_cfg_we) r_mask <= f_mask(i_cfg_wdata);
            if (i_cmd.load) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_sel <= (i_cmd.op == MODE_POP) || (i_cmd.op == MODE_PEEK);
            r_done   <= n_done;
            r_moved  <= n_moved;
            r_fill   <= fill_out_w[CNT_W-1:0];
        end
    end

    // byte memory, one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) mem[tail] <= i_data_in;
        if (i_cmd.mem_rd) r_rd_data <= mem[rd_addr];
    end

    assign o_data_out    = (r_rd_sel && r_done) ? r_rd_data : '0;
    assign o_done_res    = r_done;
    assign o_moved_count = r_moved;
    assign o_fill_level  = r_fill;

endmodule
